FILE: sv/cspa_pkg.sv
// shared types and constants for the chunked slot pool allocator
`timescale 1ns / 1ps

package cspa_pkg;

   localparam int ADDR_W              = 21;
   localparam int CFG_W               = 4;
   localparam int NUM_CHUNKS_DEF      = 8;
   localparam int SLOTS_PER_CHUNK_DEF = 64;

   localparam logic [CFG_W-1:0] SLOT_LOG2_RESET = 4'd4;

   localparam logic       KIND_ALLOC = 1'b0;
   localparam logic       KIND_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_BAD  = 2'd2;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] address_res;
   } rsp_type;

endpackage

FILE: sv/chunked_slot_pool_allocator.sv
// top level of the chunked slot pool allocator
// from acceptance to the result: allocate scans chunks, stepping one chunk per cycle through
//   the shared chunk/base counter until a chunk has room or all are full, then reads its ring;
//   free checks the range, then finds the quotient by one subtract of SLOTS_PER_CHUNK per cycle,
//   an out-of-range free skipping it; the result then waits while the previous one holds
//   the output register; one request at a time, the next accepted once the result is handed off
// reset: synchronous, active high; counts and pointers clear at once, then a clearing pass
//   loads all NUM_CHUNKS*SLOTS_PER_CHUNK free ring entries (512 by default) with the identity,
//   during which no request is accepted
`timescale 1ns / 1ps

module chunked_slot_pool_allocator
   import cspa_pkg::*;
#(
   parameter int NUM_CHUNKS      = NUM_CHUNKS_DEF,
   parameter int SLOTS_PER_CHUNK = SLOTS_PER_CHUNK_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   localparam int TOTAL = NUM_CHUNKS * SLOTS_PER_CHUNK;
   localparam int SW    = $clog2(SLOTS_PER_CHUNK);            // slot index width
   localparam int CNW   = $clog2(SLOTS_PER_CHUNK + 1);        // use count width
   localparam int CHW   = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
   localparam int RW    = $clog2(TOTAL);                      // ring address width
   localparam int CW    = (RW + 1 > ADDR_W) ? RW + 1 : ADDR_W; // global slot width

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_SCAN   = 7'b0000100,
      ST_RDWAIT = 7'b0001000,
      ST_CHECK  = 7'b0010000,
      ST_DIV    = 7'b0100000,
      ST_RESP   = 7'b1000000
   } state_type;

   state_type        state_ff;
   logic [CFG_W-1:0] slot_log2_ff;

   // per-chunk bookkeeping
   logic [CNW-1:0]   count_ff [NUM_CHUNKS];
   logic [SW-1:0]    push_ff  [NUM_CHUNKS];
   logic [SW-1:0]    pop_ff   [NUM_CHUNKS];

   // free rings, one memory for all chunks
   logic [SW-1:0]    ring [TOTAL];
   logic [SW-1:0]    ring_q;
   logic             ring_we;
   logic [RW-1:0]    ring_wa;
   logic [RW-1:0]    ring_ra;
   logic [SW-1:0]    ring_wd;

   // clearing pass counters
   logic [RW-1:0]    clr_idx_ff;
   logic [SW-1:0]    clr_slot_ff;

   // shared sequencer datapath: chunk number, chunk base and remainder
   logic [CHW-1:0]   c_ff;
   logic [RW-1:0]    base_ff;
   logic [CW-1:0]    rem_ff;
   rsp_type          res_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic             out_free;
   logic             chunk_has_room;
   logic             rem_ge_slots;
   logic [CW-1:0]    alloc_g;
   logic [CW-1:0]    alloc_off;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign chunk_has_room = (count_ff[c_ff] != CNW'(SLOTS_PER_CHUNK));
   assign rem_ge_slots   = (rem_ff >= CW'(SLOTS_PER_CHUNK));

   // popped slot plus chunk base, then scaled to bytes and wrapped to the address width
   assign alloc_g   = CW'(base_ff) + CW'(ring_q);
   assign alloc_off = alloc_g << slot_log2_ff;

   // ring port control
   always_comb begin
      ring_we = 1'b0;
      ring_wa = base_ff + RW'(push_ff[c_ff]);
      ring_wd = rem_ff[SW-1:0];
      ring_ra = base_ff + RW'(pop_ff[c_ff]);
      if (state_ff == ST_CLEAR) begin
         ring_we = 1'b1;
         ring_wa = clr_idx_ff;
         ring_wd = clr_slot_ff;
      end else if (state_ff == ST_DIV && !rem_ge_slots && count_ff[c_ff] != '0) begin
         ring_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring[ring_wa] <= ring_wd;
      end
      ring_q <= ring[ring_ra];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         slot_log2_ff <= SLOT_LOG2_RESET;
         clr_idx_ff   <= '0;
         clr_slot_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         c_ff         <= '0;
         for (int i = 0; i < NUM_CHUNKS; i++) begin
            count_ff[i] <= '0;
            push_ff[i]  <= '0;
            pop_ff[i]   <= '0;
         end
      end else begin
         // in ST_RESP the handoff below sets the flag instead
         if (!rsp_stall && state_ff != ST_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            slot_log2_ff <= csr_data;
         end

         case (state_ff)
            ST_CLEAR: begin
               // identity fill, slot index wraps per chunk
               clr_idx_ff  <= clr_idx_ff + 1'b1;
               clr_slot_ff <= (clr_slot_ff == SW'(SLOTS_PER_CHUNK - 1)) ?
                              '0 : clr_slot_ff + 1'b1;
               if (clr_idx_ff == RW'(TOTAL - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end

            ST_IDLE: begin
               if (req_valid) begin
                  c_ff    <= '0;
                  base_ff <= '0;
                  rem_ff  <= CW'(req_data.address >> slot_log2_ff);
                  state_ff <= (req_data.kind == KIND_ALLOC) ? ST_SCAN : ST_CHECK;
               end
            end

            ST_SCAN: begin
               // one chunk per cycle, first with room wins
               if (chunk_has_room) begin
                  pop_ff[c_ff]   <= (pop_ff[c_ff] == SW'(SLOTS_PER_CHUNK - 1)) ?
                                    '0 : pop_ff[c_ff] + 1'b1;
                  count_ff[c_ff] <= count_ff[c_ff] + 1'b1;
                  state_ff       <= ST_RDWAIT;
               end else if (c_ff == CHW'(NUM_CHUNKS - 1)) begin
                  res_ff.status      <= STATUS_FULL;
                  res_ff.address_res <= '0;
                  state_ff           <= ST_RESP;
               end else begin
                  c_ff    <= c_ff + 1'b1;
                  base_ff <= base_ff + RW'(SLOTS_PER_CHUNK);
               end
            end

            ST_RDWAIT: begin
               // ring read data lands here
               res_ff.status      <= STATUS_OK;
               res_ff.address_res <= alloc_off[ADDR_W-1:0];
               state_ff           <= ST_RESP;
            end

            ST_CHECK: begin
               if (rem_ff >= CW'(TOTAL)) begin
                  res_ff.status      <= STATUS_BAD;
                  res_ff.address_res <= '0;
                  state_ff           <= ST_RESP;
               end else begin
                  state_ff <= ST_DIV;
               end
            end

            ST_DIV: begin
               // chunk = quotient by repeated subtract, slot = what is left
               if (rem_ge_slots) begin
                  rem_ff  <= rem_ff - CW'(SLOTS_PER_CHUNK);
                  c_ff    <= c_ff + 1'b1;
                  base_ff <= base_ff + RW'(SLOTS_PER_CHUNK);
               end else begin
                  res_ff.address_res <= '0;
                  if (count_ff[c_ff] == '0) begin
                     res_ff.status <= STATUS_BAD;
                  end else begin
                     res_ff.status  <= STATUS_OK;
                     push_ff[c_ff]  <= (push_ff[c_ff] == SW'(SLOTS_PER_CHUNK - 1)) ?
                                       '0 : push_ff[c_ff] + 1'b1;
                     count_ff[c_ff] <= count_ff[c_ff] - 1'b1;
                  end
                  state_ff <= ST_RESP;
               end
            end

            ST_RESP: begin
               // hand off once the output register is free
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_ff;
                  state_ff     <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: tb/tb_top.sv
// testbench for the chunked slot pool allocator: predictor, scoreboard and request drivers
`timescale 1ns / 1ps

module tb_top
   import cspa_pkg::*;
   ;

   localparam int SLOT_W      = $clog2(SLOTS_PER_CHUNK_DEF);
   localparam int TOTAL_SLOTS = NUM_CHUNKS_DEF * SLOTS_PER_CHUNK_DEF;
   localparam int RAND_ITEMS  = 1740;
   localparam int NUM_PHASES  = 6;
   // longest stretch with no handshake at all; covers the ring clearing pass
   localparam int QUIET_LIMIT = 4000;
   // slot size per random phase, phase 0 in the low nibble: both extremes and above range
   localparam logic [NUM_PHASES*CFG_W-1:0] PHASE_LOG2 =
      {4'd4, 4'd1, 4'd7, 4'd15, 4'd12, 4'd0};

   // ---------------------------------------------------------------------------------------
   // slot pool predictor and result scoreboard
   // ---------------------------------------------------------------------------------------
   class slot_pool_scoreboard;
      logic [CFG_W-1:0]  slot_log2;
      logic [SLOT_W-1:0] free_ring [NUM_CHUNKS_DEF][SLOTS_PER_CHUNK_DEF];
      logic [SLOT_W-1:0] push_ptr  [NUM_CHUNKS_DEF];
      logic [SLOT_W-1:0] pop_ptr   [NUM_CHUNKS_DEF];
      logic [SLOT_W:0]   use_count [NUM_CHUNKS_DEF];
      rsp_type           expected_rsp [$];
      int                granted_slot;
      int                errors;
      int                n_checked;
      int                n_granted;
      int                n_full;
      int                n_rejected;
      int                n_released;

      function new();
         slot_log2 = SLOT_LOG2_RESET;
         for (int c = 0; c < NUM_CHUNKS_DEF; c++) begin
            push_ptr[c]  = '0;
            pop_ptr[c]   = '0;
            use_count[c] = '0;
            for (int i = 0; i < SLOTS_PER_CHUNK_DEF; i++)
               free_ring[c][i] = SLOT_W'(i);
         end
         granted_slot = -1;
         errors       = 0;
         n_checked    = 0;
         n_granted    = 0;
         n_full       = 0;
         n_rejected   = 0;
         n_released   = 0;
      endfunction

      function void set_slot_log2(logic [CFG_W-1:0] v);
         slot_log2 = v;
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      // update the pool for one accepted request and queue the response it must produce
      function rsp_type note_request(req_type r);
         rsp_type     exp;
         logic [31:0] g;
         int          c;
         int          slot;
         exp          = '0;
         granted_slot = -1;
         if (r.kind == KIND_ALLOC) begin
            c = 0;
            while (c < NUM_CHUNKS_DEF && use_count[c] >= SLOTS_PER_CHUNK_DEF)
               c++;
            if (c < NUM_CHUNKS_DEF) begin
               granted_slot    = c * SLOTS_PER_CHUNK_DEF + int'(free_ring[c][pop_ptr[c]]);
               pop_ptr[c]      = pop_ptr[c] + 1'b1;
               use_count[c]    = use_count[c] + 1'b1;
               g               = 32'(granted_slot) << slot_log2;
               exp.status      = STATUS_OK;
               exp.address_res = g[ADDR_W-1:0];
               n_granted++;
            end else begin
               exp.status = STATUS_FULL;
               n_full++;
            end
         end else begin
            g = 32'(r.address) >> slot_log2;
            if (g >= TOTAL_SLOTS) begin
               exp.status = STATUS_BAD;
               n_rejected++;
            end else begin
               c    = int'(g) / SLOTS_PER_CHUNK_DEF;
               slot = int'(g) % SLOTS_PER_CHUNK_DEF;
               if (use_count[c] == 0) begin
                  exp.status = STATUS_BAD;
                  n_rejected++;
               end else begin
                  free_ring[c][push_ptr[c]] = SLOT_W'(slot);
                  push_ptr[c]               = push_ptr[c] + 1'b1;
                  use_count[c]              = use_count[c] - 1'b1;
                  exp.status                = STATUS_OK;
                  n_released++;
               end
            end
         end
         expected_rsp.push_back(exp);
         return exp;
      endfunction

      task report_mismatch(string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_result(rsp_type got);
         rsp_type exp;
         if (expected_rsp.size() == 0) begin
            report_mismatch($sformatf("response with none outstanding: status %0d address %0h",
                                      got.status, got.address_res));
            return;
         end
         exp = expected_rsp.pop_front();
         n_checked++;
         if (got.status !== exp.status)
            report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                      n_checked, got.status, exp.status));
         if (got.address_res !== exp.address_res)
            report_mismatch($sformatf("response %0d address %0h, expected %0h",
                                      n_checked, got.address_res, exp.address_res));
      endtask
   endclass

   // ---------------------------------------------------------------------------------------
   // clock, reset and block under test
   // ---------------------------------------------------------------------------------------
   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data  = SLOT_LOG2_RESET;

   slot_pool_scoreboard sb;
   int                  tx_idle_pct;
   int                  rx_idle_pct;
   int                  live_slots [$];   // global slot numbers believed to be allocated
   bit                  filling;          // alloc-heavy until the pool has run full a few times
   int                  fulls_seen;
   int                  n_requests;
   int                  n_cfg_writes;
   int                  quiet_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   chunked_slot_pool_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // ---------------------------------------------------------------------------------------
   // response side: random backpressure and checking
   // ---------------------------------------------------------------------------------------

   // stall is redrawn every cycle, even while a response is held
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   // values read here are the ones from just before the edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_data);
   end

   // watchdog: any accepted request, response or register write resets the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles, %0d responses outstanding",
                  $time, QUIET_LIMIT, sb.pending());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------------------

   // present one request, hold it until accepted, then hand it to the predictor;
   // valid is only lowered when an idle cycle is inserted, so back-to-back stays high
   task automatic send_request(input logic kind, input logic [ADDR_W-1:0] addr);
      req_type item;
      rsp_type exp;
      item.kind    = kind;
      item.address = addr;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      exp = sb.note_request(item);
      n_requests++;
      if (exp.status == STATUS_FULL)
         fulls_seen++;
      if (sb.granted_slot >= 0)
         live_slots.push_back(sb.granted_slot);
   endtask

   // register writes only with the pool idle: stop sending and wait out every response
   task automatic write_slot_log2(input logic [CFG_W-1:0] v);
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_slot_log2(v);
      n_cfg_writes++;
   endtask

   // mostly well-formed traffic: alloc-heavy until the pool has run full three times, then free-heavy until
   // everything handed out has come back; a little noise with fully random fields
   task automatic run_random_phase(input int n_items);
      int          roll;
      int          idx;
      int          g;
      logic [31:0] a32;
      for (int k = 0; k < n_items; k++) begin
         roll = $urandom_range(99);
         if (roll < 6) begin
            send_request(1'($urandom), ADDR_W'($urandom));
         end else if (roll < (filling ? 92 : 16)) begin
            send_request(KIND_ALLOC, ADDR_W'($urandom));
         end else begin
            if (live_slots.size() > 0) begin
               idx = $urandom_range(live_slots.size() - 1);
               g   = live_slots[idx];
               live_slots.delete(idx);
            end else begin
               g = $urandom_range(TOTAL_SLOTS - 1);
            end
            // random low bits: an unaligned offset still names the slot that holds it
            a32 = (32'(g) << sb.slot_log2) | ($urandom & ((32'd1 << sb.slot_log2) - 1));
            send_request(KIND_FREE, a32[ADDR_W-1:0]);
         end
         if (filling && fulls_seen >= 3) begin
            filling = 1'b0;
         end else if (!filling && live_slots.size() == 0) begin
            filling    = 1'b1;
            fulls_seen = 0;
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      int ph;
      sb           = new();
      tx_idle_pct  = 11;
      rx_idle_pct  = 51;
      filling      = 1'b1;
      fulls_seen   = 0;
      n_requests   = 0;
      n_cfg_writes = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset slot size of 16 bytes
      send_request(KIND_ALLOC, '0);
      send_request(KIND_ALLOC, '1);                 // address ignored on allocate
      send_request(KIND_ALLOC, '0);
      send_request(KIND_FREE, ADDR_W'(21));          // unaligned, names slot 1
      send_request(KIND_FREE, ADDR_W'(16));          // same slot again while count nonzero
      send_request(KIND_FREE, '0);                   // chunk 0 count back to zero
      send_request(KIND_FREE, ADDR_W'(32));          // free on an empty chunk
      send_request(KIND_FREE, '1);                   // far out of range
      send_request(KIND_FREE, ADDR_W'(TOTAL_SLOTS << 4));      // first slot past the pool
      send_request(KIND_FREE, ADDR_W'((TOTAL_SLOTS << 4) - 1)); // last slot, chunk unused
      send_request(KIND_ALLOC, '0);
      send_request(KIND_ALLOC, '0);

      // one-byte slots
      write_slot_log2(4'd0);
      send_request(KIND_ALLOC, '0);
      send_request(KIND_FREE, ADDR_W'(TOTAL_SLOTS - 1));
      send_request(KIND_FREE, ADDR_W'(TOTAL_SLOTS));
      send_request(KIND_FREE, ADDR_W'(1));

      // largest legal slot size
      write_slot_log2(4'd12);
      send_request(KIND_ALLOC, '0);
      send_request(KIND_FREE, '1);
      send_request(KIND_FREE, ADDR_W'((2 << 12) + 100));

      // above range: offsets wrap at 21 bits
      write_slot_log2(4'd15);
      send_request(KIND_ALLOC, '0);
      send_request(KIND_ALLOC, '0);
      send_request(KIND_FREE, '1);

      // random part; every phase change drains the pool's responses first
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph == 2) begin
            tx_idle_pct = 51;
            rx_idle_pct = 11;
         end else if (ph == 4) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         write_slot_log2(PHASE_LOG2[ph*CFG_W +: CFG_W]);
         run_random_phase(RAND_ITEMS / NUM_PHASES);
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      $display("covered %0d requests over %0d slot size settings (0, 1, 4, 7, 12, 15)",
               n_requests, n_cfg_writes + 1);
      $display("  %0d slots granted, %0d pool full, %0d slots returned, %0d frees rejected",
               sb.n_granted, sb.n_full, sb.n_released, sb.n_rejected);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
